### rtl/fcle_pkg.sv
`default_nettype none

package fcle_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [4:0] CAP_RESET = 5'd5;

    localparam logic [2:0] REG_CAPACITY = 3'd0;

    typedef struct packed {
        logic append;
        logic remove;
        logic rotate;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/fcle_cell.sv
`default_nettype none

module fcle_cell #(
    parameter int CELL_IDX = 0,
    parameter int CW       = 5
) (
    input  wire                    i_clk,
    input  wire fcle_pkg::t_cell_ctl i_ctl,
    input  wire [CW-1:0]           i_count,
    input  wire [3:0]              i_idx,
    input  wire [31:0]             i_value,
    input  wire [31:0]             i_next,
    input  wire [31:0]             i_head,
    output logic [31:0]            o_data
);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        below_last;
    logic        is_last;
    logic        is_tail;

    assign below_last = (CELL_IDX + 1) < int'(i_count);
    assign is_last    = (CELL_IDX + 1) == int'(i_count);
    assign is_tail    = CELL_IDX == int'(i_count);

    always_comb begin
        n_data = r_data;
        if (i_ctl.append && is_tail) begin
            n_data = i_value;
        end else if (i_ctl.remove && below_last && (CELL_IDX >= int'(i_idx))) begin
            n_data = i_next;
        end else if (i_ctl.rotate) begin
            if (below_last) begin
                n_data = i_next;
            end else if (is_last) begin
                n_data = i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/fixed_capacity_list_engine.sv
// Fixed-capacity list engine.
// Input stream (s_axis): one word per operation, tdata holds operation [1:0],
// value [33:2] (signed), index [37:34]. Output stream (m_axis): one word per
// operation, tdata holds status [1:0], found_index [5:2], entry_count [10:6].
// APB port: register capacity_limit at byte address 0, written by the user
// only while idle; the block does not enforce this. Entries live in a row of
// cells, one entry per cell. Append and remove load or shift the cells in one
// step, so the result is registered in the cycle after the word is taken. Find
// rotates the occupied cells through cell 0 one place per cycle and compares
// there; after count steps the list is back in order. A find on an empty list
// returns not found without rotating; a new word is taken once a find ends.
// Operation code 3 returns ok and leaves the list unchanged.
// Reset clears the entry count and sets capacity_limit to 5; cell contents
// are left as they are. When the receiver stalls, the result word holds in
// the output register; a new word is taken only when that register frees in
// the same cycle, and a finishing find holds its last step until then.
`default_nettype none

module fixed_capacity_list_engine #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // operation, value, index
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status, found_index, entry_count
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = $clog2(MAX_ENTRIES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIND = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [SW-1:0] r_step;
    logic [SW-1:0] n_step;
    logic          r_hit;
    logic          n_hit;
    logic [SW-1:0] r_found;
    logic [SW-1:0] n_found;
    logic [31:0]   r_value;
    logic [31:0]   n_value;
    logic [4:0]    r_cap;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [10:0]   r_out;
    logic [10:0]   n_out;

    logic [1:0]    in_op;
    logic [31:0]   in_value;
    logic [3:0]    in_idx;
    logic          accept;
    logic          out_free;
    logic          full;
    logic          bad_idx;
    logic          match;
    logic          last;
    logic          advance;
    fcle_pkg::t_cell_ctl cell_ctl;
    logic [31:0]   cell_data [MAX_ENTRIES];

    assign in_op    = s_axis_tdata[1:0];
    assign in_value = s_axis_tdata[33:2];
    assign in_idx   = s_axis_tdata[37:34];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full    = (int'(r_count) >= int'(r_cap)) || (r_count == CW'(MAX_ENTRIES));
    assign bad_idx = int'(in_idx) >= int'(r_count);
    assign match   = cell_data[0] == r_value;
    assign last    = CW'(r_step) == (r_count - CW'(1));
    assign advance = (r_state == S_FIND) && (!last || out_free);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_hit       = r_hit;
        n_found     = r_found;
        n_value     = r_value;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        cell_ctl    = '0;
        if (accept) begin
            n_out_valid = 1'b1;
            n_out       = {5'(r_count), 4'd0, fcle_pkg::ST_OK};
            case (in_op)
                fcle_pkg::OP_APPEND: begin
                    if (full) begin
                        n_out[1:0] = fcle_pkg::ST_FULL;
                    end else begin
                        cell_ctl.append = 1'b1;
                        n_count         = r_count + CW'(1);
                        n_out[10:6]     = 5'(r_count + CW'(1));
                    end
                end
                fcle_pkg::OP_FIND: begin
                    if (r_count == '0) begin
                        n_out[1:0] = fcle_pkg::ST_NOT_FOUND;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_FIND;
                        n_step      = '0;
                        n_hit       = 1'b0;
                        n_value     = in_value;
                    end
                end
                fcle_pkg::OP_REMOVE: begin
                    if (bad_idx) begin
                        n_out[1:0] = fcle_pkg::ST_BAD_INDEX;
                    end else begin
                        cell_ctl.remove = 1'b1;
                        n_count         = r_count - CW'(1);
                        n_out[10:6]     = 5'(r_count - CW'(1));
                    end
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            cell_ctl.rotate = 1'b1;
            n_step          = r_step + SW'(1);
            if (match && !r_hit) begin
                n_hit   = 1'b1;
                n_found = r_step;
            end
            if (last) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_hit) begin
                    n_out = {5'(r_count), 4'(r_found), fcle_pkg::ST_OK};
                end else if (match) begin
                    n_out = {5'(r_count), 4'(r_step), fcle_pkg::ST_OK};
                end else begin
                    n_out = {5'(r_count), 4'd0, fcle_pkg::ST_NOT_FOUND};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= fcle_pkg::CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready && (paddr[2] == fcle_pkg::REG_CAPACITY[0])) begin
                r_cap <= pwdata[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_value <= n_value;
        r_out   <= n_out;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            fcle_cell #(
                .CELL_IDX (g),
                .CW       (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_count (r_count),
                .i_idx   (in_idx),
                .i_value (in_value),
                .i_next  (cell_data[(g + 1 < MAX_ENTRIES) ? g + 1 : g]),
                .i_head  (cell_data[0]),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == fcle_pkg::REG_CAPACITY[0]) ? {27'd0, r_cap} : 32'd0;

endmodule

`default_nettype wire

### rtl/fcle_checker.sv
`default_nettype none

module fcle_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_full_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == fcle_pkg::ST_FULL) |-> m_axis_tdata[5:2] == 4'd0)
        else $error("full result carries an index");

    a_bad_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == fcle_pkg::ST_BAD_INDEX)
        |-> m_axis_tdata[5:2] == 4'd0)
        else $error("invalid index result carries an index");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind fixed_capacity_list_engine fcle_checker u_fcle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
